/* rtl/core/dgll_pkg.sv */
// Shared types and constants for the diagonal Gaussian log-likelihood scorer.
`timescale 1ns / 1ps
`default_nettype none

package dgll_pkg;

  localparam int VAL_W   = 32;  // Q16.16 operand width
  localparam int IDX_W   = 6;   // load index width
  localparam int DIM_W   = 7;   // dim register width
  localparam int ACC_W   = 64;  // accumulator width
  localparam int TERM_W  = 63;  // capped quadratic term width
  localparam int CFG_W   = 32;  // widest configuration register
  localparam int S_TDATA_W = 136;  // 134 payload bits padded to whole bytes
  localparam int M_TDATA_W = 32;

  // Configuration register indexes
  localparam logic REG_DIM      = 1'b0;
  localparam logic REG_LOG_NORM = 1'b1;

  // Input selector carried on tuser
  localparam logic FUNC_SCORE = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  // Result for a vector whose element count did not match dim (minus infinity)
  localparam logic [VAL_W-1:0] NEG_INF = 32'h8000_0000;

  // Upper limit of one quadratic term, 2^62
  localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, 62'b0};

  typedef struct packed {
    logic [VAL_W-1:0] log_var;
    logic [VAL_W-1:0] inv_var;
    logic [VAL_W-1:0] mean;
  } entry_t;

  // Per-element control travelling alongside the arithmetic
  typedef struct packed {
    logic add;   // element lies inside dim and the table
    logic last;  // final element of the vector
    logic ok;    // element count matched dim at the last element
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/core/diagonal_gaussian_log_likelihood.sv */
// Top level of the diagonal Gaussian log-likelihood scorer.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: index, x, mean, inv_var, log_var
//                                                tuser: func, tlast: last
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: log_prob, tuser: valid_res
//  cfg       in   cfg_we                         cfg_index, cfg_data
//
// One input transfer per cycle unless a result is stalled. The parameter table
// sits in a synchronous memory read at the element position when a score
// element is taken; the term then runs through a five-stage multiply pipeline,
// one accumulate stage and the output register. The accumulate add is the only
// feedback loop in the arithmetic.
// Reset (synchronous, rst high) clears the position, accumulator and valids;
// the table holds nothing meaningful until loaded.
// The whole pipeline freezes while a result waits on m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module diagonal_gaussian_log_likelihood #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst,
  // slave side
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [135:0] s_axis_tdata,   // index[5:0], x_value[37:6], mean_value[69:38],
                                       // inv_var_value[101:70], log_var_value[133:102]
  input  wire          s_axis_tuser,   // func
  input  wire          s_axis_tlast,   // last
  // master side
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // log_prob[31:0]
  output logic         m_axis_tuser,   // valid_res
  // configuration
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire  [31:0]  cfg_data
);
  import dgll_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;  // table address
  localparam int PW = $clog2(MAX_DIM + 2);                  // position count

  // configuration registers
  logic [DIM_W-1:0] dim;
  logic [VAL_W-1:0] log_norm;

  // input unpacking
  logic [IDX_W-1:0] in_index;
  logic [VAL_W-1:0] in_x;
  entry_t           in_entry;

  // handshake and pipeline enable
  logic advance;
  logic take_score;
  logic take_load;

  // position tracking
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  ctl_t          in_ctl;

  // parameter memory
  entry_t           table_mem [MAX_DIM];
  entry_t           rd_entry;
  logic             s1_valid;
  ctl_t             s1_ctl;
  logic [VAL_W-1:0] s1_x;

  // term pipeline outputs
  logic        t_valid;
  ctl_t        t_ctl;
  logic [63:0] t_term;

  // accumulate and finish
  logic [ACC_W-1:0]        acc;
  logic signed [ACC_W:0]   acc_sum_wide;
  logic [ACC_W-1:0]        acc_sum;
  logic                    fin_valid;
  logic                    fin_ok;
  logic [ACC_W-1:0]        fin_acc;
  logic signed [ACC_W:0]   res_wide;
  logic [VAL_W-1:0]        res_sat;

  assign in_index         = s_axis_tdata[5:0];
  assign in_x             = s_axis_tdata[37:6];
  assign in_entry.mean    = s_axis_tdata[69:38];
  assign in_entry.inv_var = s_axis_tdata[101:70];
  assign in_entry.log_var = s_axis_tdata[133:102];

  // Everything moves together unless a result sits unclaimed at the output.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign take_score    = s_axis_tvalid && advance && (s_axis_tuser == FUNC_SCORE);
  assign take_load     = s_axis_tvalid && advance && (s_axis_tuser == FUNC_LOAD);

  // Count saturates one beyond the table so an overlong vector stays invalid.
  always_comb begin
    pos_next = (32'(pos) < MAX_DIM + 1) ? pos + PW'(1) : pos;
    in_ctl.add  = (32'(pos) < 32'(dim)) && (32'(pos) < MAX_DIM);
    in_ctl.last = s_axis_tlast;
    in_ctl.ok   = (dim != '0) && (32'(dim) <= MAX_DIM) && (32'(pos_next) == 32'(dim));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dim      <= DIM_W'(1);
      log_norm <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM:      dim      <= cfg_data[DIM_W-1:0];
        REG_LOG_NORM: log_norm <= cfg_data;
        default: ;
      endcase
    end
  end

  // table: loads write, score elements read at the current position
  always_ff @(posedge clk) begin
    if (take_load && (32'(in_index) < MAX_DIM)) begin
      table_mem[AW'(in_index)] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_entry <= table_mem[pos[AW-1:0]];
      s1_ctl   <= in_ctl;
      s1_x     <= in_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= take_score;
      if (take_score) begin
        pos <= s_axis_tlast ? '0 : pos_next;
      end
    end
  end

  dgll_term #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s1_valid),
    .in_ctl    (s1_ctl),
    .x         (s1_x),
    .entry     (rd_entry),
    .out_valid (t_valid),
    .out_ctl   (t_ctl),
    .term      (t_term)
  );

  // saturating 64-bit accumulate; out-of-range elements contribute nothing
  always_comb begin
    acc_sum_wide = $signed({acc[ACC_W-1], acc}) + $signed({t_term[ACC_W-1], t_term});
    if (!t_ctl.add) begin
      acc_sum = acc;
    end else if (acc_sum_wide[ACC_W] != acc_sum_wide[ACC_W-1]) begin
      acc_sum = acc_sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sum = acc_sum_wide[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fin_valid <= 1'b0;
    end else if (advance) begin
      fin_valid <= t_valid && t_ctl.last;
      if (t_valid) begin
        acc <= t_ctl.last ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fin_acc <= acc_sum;
      fin_ok  <= t_ctl.ok;
    end
  end

  // -log_normalizer - floor(acc / 2), clipped to 32 bits
  always_comb begin
    res_wide = -$signed({{(ACC_W+1-VAL_W){log_norm[VAL_W-1]}}, log_norm})
               - $signed({{2{fin_acc[ACC_W-1]}}, fin_acc[ACC_W-1:1]});
    if (res_wide > $signed((ACC_W+1)'(32'h7FFF_FFFF))) begin
      res_sat = 32'h7FFF_FFFF;
    end else if (res_wide < -$signed((ACC_W+1)'(33'h0_8000_0000))) begin
      res_sat = NEG_INF;
    end else begin
      res_sat = res_wide[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= fin_ok ? res_sat : NEG_INF;
      m_axis_tuser <= fin_ok;
    end
  end

  // an invalid vector always reports minus infinity
  a_neg_inf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == NEG_INF)
    else $error("invalid result without minus-infinity code");

  // the accumulator starts afresh after each vector's last element
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    advance && t_valid && t_ctl.last |=> acc == '0)
    else $error("accumulator not cleared after last element");

  // position never runs past its saturation point
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pos) <= MAX_DIM + 1)
    else $error("element position out of range");

  // a stalled output holds the pipeline: no input transfer while it waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

endmodule

`default_nettype wire

/* rtl/core/dgll_term.sv */
// Pipelined quadratic term: log_var + ((x - mean)^2 * inv_var), fixed point.
`timescale 1ns / 1ps
`default_nettype none

module dgll_term #(
  parameter int FRAC_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         en,
  input  wire                         in_valid,
  input  wire  dgll_pkg::ctl_t        in_ctl,
  input  wire  [31:0]                 x,
  input  wire  dgll_pkg::entry_t      entry,
  output logic                        out_valid,
  output dgll_pkg::ctl_t              out_ctl,
  output logic [63:0]                 term
);
  import dgll_pkg::*;

  localparam int SQW = 2 * (VAL_W + 1) - FRAC_BITS;  // truncated square
  localparam int SUW = SQW + VAL_W;                  // full square * inv_var
  localparam int RW  = SUW - FRAC_BITS;              // after the shift
  localparam int CW  = (RW > TERM_W) ? RW : TERM_W;  // compare width

  // stage 2: magnitude of x - mean
  logic             s2_valid;
  ctl_t             s2_ctl;
  logic [VAL_W:0]   s2_mag;
  logic [VAL_W-1:0] s2_inv, s2_lv;
  // stage 3: square
  logic             s3_valid;
  ctl_t             s3_ctl;
  logic [SQW-1:0]   s3_sq;
  logic [VAL_W-1:0] s3_inv, s3_lv;
  // stage 4: partial products
  logic             s4_valid;
  ctl_t             s4_ctl;
  logic [63:0]      s4_pp_lo;
  logic [SQW-1:0]   s4_pp_hi;
  logic [VAL_W-1:0] s4_lv;
  // stage 5: capped term
  logic              s5_valid;
  ctl_t              s5_ctl;
  logic [TERM_W-1:0] s5_quad;
  logic [VAL_W-1:0]  s5_lv;

  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]        mag;
  logic [2*VAL_W+1:0]    prod;
  logic [SUW-1:0]        full;
  logic [RW-1:0]         shifted;
  logic [TERM_W-1:0]     quad;

  always_comb begin
    diff = $signed({x[VAL_W-1], x}) - $signed({entry.mean[VAL_W-1], entry.mean});
    mag  = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
    prod = (2*VAL_W+2)'(s2_mag) * (2*VAL_W+2)'(s2_mag);
    full = {s4_pp_hi, {VAL_W{1'b0}}} + SUW'(s4_pp_lo);
    shifted = full[SUW-1:FRAC_BITS];
    if (CW'(shifted) > CW'(TERM_CAP)) begin
      quad = TERM_CAP;
    end else begin
      quad = TERM_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s2_valid  <= in_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl   <= in_ctl;
      s2_mag   <= mag;
      s2_inv   <= entry.inv_var;
      s2_lv    <= entry.log_var;

      s3_ctl   <= s2_ctl;
      s3_sq    <= prod[2*VAL_W+1:FRAC_BITS];
      s3_inv   <= s2_inv;
      s3_lv    <= s2_lv;

      s4_ctl   <= s3_ctl;
      s4_pp_lo <= 64'(s3_sq[VAL_W-1:0]) * 64'(s3_inv);
      s4_pp_hi <= SQW'(s3_sq[SQW-1:VAL_W]) * SQW'(s3_inv);
      s4_lv    <= s3_lv;

      s5_ctl   <= s4_ctl;
      s5_quad  <= quad;
      s5_lv    <= s4_lv;

      out_ctl  <= s5_ctl;
      term     <= {1'b0, s5_quad} + {{(ACC_W-VAL_W){s5_lv[VAL_W-1]}}, s5_lv};
    end
  end

endmodule

`default_nettype wire
